/* src/trq_pkg.sv */
// ----------------------------------------------------------------------------
// trq_pkg
// Types and constants shared by the transaction requester modules.
// ----------------------------------------------------------------------------
package trq_pkg;

    // width for offset / length arithmetic: covers a 16-bit length plus carry
    localparam int CALC_W     = 17;
    localparam int SEGS       = 8;
    localparam logic [7:0] TRIES_UNLIMITED = 8'hFF;
    localparam logic [8:0] TICKS_MAX       = 9'd511;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_RESP  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PENDING  = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_FAILED   = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic        xo_mode;
        logic [15:0] want_len;
        logic        want_user_bytes;
        logic [7:0]  attempts;
        logic [7:0]  retry_interval;
        logic [15:0] pkt_tid;
        logic [2:0]  seg_seq;
        logic        eom;
        logic        sts;
        logic [9:0]  data_len;
        logic [31:0] pkt_user_bytes;
    } t_in_item;

    typedef struct packed {
        logic        send_request;
        logic        send_release;
        logic [15:0] tid_out;
        logic [7:0]  req_bitmap;
        t_status     status;
        logic        write_data;
        logic [11:0] copy_offset;
        logic [9:0]  copy_len;
        logic [15:0] response_len;
        logic [31:0] resp_user_bytes;
    } t_result;

    // handshake between the input stage and the result stage
    typedef struct packed {
        logic fire;
    } t_flow;

endpackage

/* src/trq_in_stage.sv */
// ----------------------------------------------------------------------------
// trq_in_stage
// Input register: captures one beat and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
module trq_in_stage
    import trq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output t_in_item o_item,
    output t_flow    o_flow
);

    logic     r_valid;
    t_in_item r_item;
    logic     fire;

    assign fire    = r_valid && i_out_free;
    assign o_stall = r_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_item      = r_item;
    assign o_flow.fire = fire;

endmodule

/* src/trq_engine.sv */
// ----------------------------------------------------------------------------
// trq_engine
// Transaction state and the single-pass update that forms each result.
// ----------------------------------------------------------------------------
module trq_engine
    import trq_pkg::*;
#(
    parameter int SEGMENT_BYTES = 578
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  t_flow    i_flow,
    output t_result  o_result
);

    localparam logic [CALC_W-1:0] SEG = CALC_W'(SEGMENT_BYTES);

    logic [15:0] r_next_tid, n_next_tid;
    logic [15:0] r_cur_tid, n_cur_tid;
    logic [7:0]  r_bitmap, n_bitmap;
    t_status     r_status, n_status;
    logic        r_xo, n_xo;
    logic [7:0]  r_tries, n_tries;
    logic [7:0]  r_interval, n_interval;
    logic [8:0]  r_ticks, n_ticks;
    logic [15:0] r_buf_len, n_buf_len;
    logic [15:0] r_res_len, n_res_len;
    logic [31:0] r_user, n_user;

    logic [7:0]        start_map;
    logic [CALC_W-1:0] off;
    logic [CALC_W-1:0] dl;
    logic [CALC_W-1:0] cur;
    logic [CALC_W-1:0] fix;
    logic              present;
    logic [7:0]        seg_bit;
    logic              do_tx;
    logic              req, rel, wr;

    // segment k is wanted when the buffer reaches past k segments
    always_comb begin
        for (int k = 0; k < SEGS; k++) begin
            start_map[k] = {1'b0, i_item.want_len} > CALC_W'(k * SEGMENT_BYTES);
        end
    end

    always_comb begin
        off     = CALC_W'(i_item.seg_seq) * SEG;
        dl      = ({7'd0, i_item.data_len} > SEG) ? SEG : CALC_W'(i_item.data_len);
        cur     = {1'b0, r_res_len};
        present = (r_buf_len != 16'd0);
        seg_bit = 8'd1 << i_item.seg_seq;
        fix     = '0;
        if (present && cur >= off) begin
            fix = (cur >= off + dl) ? dl : cur - off;
        end
    end

    always_comb begin
        n_next_tid = r_next_tid;
        n_cur_tid  = r_cur_tid;
        n_bitmap   = r_bitmap;
        n_status   = r_status;
        n_xo       = r_xo;
        n_tries    = r_tries;
        n_interval = r_interval;
        n_ticks    = r_ticks;
        n_buf_len  = r_buf_len;
        n_res_len  = r_res_len;
        n_user     = r_user;
        do_tx      = 1'b0;
        req        = 1'b0;
        rel        = 1'b0;
        wr         = 1'b0;

        case (i_item.cmd)
            CMD_START: begin
                n_xo       = i_item.xo_mode;
                n_bitmap   = (i_item.want_len != 16'd0) ? start_map
                                                        : {7'd0, i_item.want_user_bytes};
                n_cur_tid  = r_next_tid;
                n_next_tid = r_next_tid + 16'd1;
                n_tries    = i_item.attempts;
                n_interval = i_item.retry_interval;
                n_buf_len  = i_item.want_len;
                n_res_len  = i_item.want_len;
                n_user     = '0;
                n_ticks    = '0;
                n_status   = ST_PENDING;
                do_tx      = 1'b1;
            end
            CMD_RESP: begin
                if (r_status == ST_PENDING && i_item.pkt_tid == r_cur_tid) begin
                    if ((r_bitmap & seg_bit) != 8'd0) begin
                        wr = present;
                        if (i_item.eom) begin
                            n_bitmap = r_bitmap & (seg_bit - 8'd1);
                        end else begin
                            n_bitmap = r_bitmap & ~seg_bit;
                        end
                        if (i_item.seg_seq == 3'd0) begin
                            n_user = i_item.pkt_user_bytes;
                        end
                        if (i_item.eom && present) begin
                            n_res_len = 16'(off + fix);
                        end
                    end
                    if (n_bitmap == 8'd0) begin
                        rel      = r_xo;
                        n_status = ST_COMPLETE;
                    end
                    do_tx = i_item.sts && (n_status == ST_PENDING);
                end
            end
            CMD_TICK: begin
                if (r_status == ST_PENDING) begin
                    if (r_ticks < TICKS_MAX) begin
                        n_ticks = r_ticks + 9'd1;
                    end
                    do_tx = (n_ticks > {1'b0, r_interval});
                end
            end
            default: begin
            end
        endcase

        // (re)transmission: fails once tries are used up
        if (do_tx) begin
            if (n_tries == 8'd0) begin
                n_status = ST_FAILED;
            end else begin
                req     = 1'b1;
                n_ticks = '0;
                if (n_tries != TRIES_UNLIMITED) begin
                    n_tries = n_tries - 8'd1;
                end
            end
        end
    end

    always_comb begin
        o_result.send_request    = req;
        o_result.send_release    = rel;
        o_result.tid_out         = n_cur_tid;
        o_result.req_bitmap      = n_bitmap;
        o_result.status          = n_status;
        o_result.write_data      = wr;
        o_result.copy_offset     = wr ? off[11:0] : 12'd0;
        o_result.copy_len        = wr ? fix[9:0] : 10'd0;
        o_result.response_len    = n_res_len;
        o_result.resp_user_bytes = n_user;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_tid <= '0;
            r_cur_tid  <= '0;
            r_bitmap   <= '0;
            r_status   <= ST_IDLE;
            r_xo       <= 1'b0;
            r_tries    <= '0;
            r_interval <= '0;
            r_ticks    <= '0;
            r_buf_len  <= '0;
            r_res_len  <= '0;
            r_user     <= '0;
        end else if (i_flow.fire) begin
            r_next_tid <= n_next_tid;
            r_cur_tid  <= n_cur_tid;
            r_bitmap   <= n_bitmap;
            r_status   <= n_status;
            r_xo       <= n_xo;
            r_tries    <= n_tries;
            r_interval <= n_interval;
            r_ticks    <= n_ticks;
            r_buf_len  <= n_buf_len;
            r_res_len  <= n_res_len;
            r_user     <= n_user;
        end
    end

endmodule

/* src/trq_out_stage.sv */
// ----------------------------------------------------------------------------
// trq_out_stage
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module trq_out_stage
    import trq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* src/transaction_requester_unit.sv */
// ----------------------------------------------------------------------------
// transaction_requester_unit
// Requester side of one reliable request-response transaction.
// ----------------------------------------------------------------------------
// Each beat (start, response packet or one second tick) yields exactly one
// result beat. A beat is captured in an input register, processed against
// the transaction state in a single combinational pass and written to a
// result register, so the unit takes one beat per cycle when the result
// side does not stall; the result register lets a new beat be processed
// in the same cycle that the previous result is taken. A stall on the result
// side holds the result register, and once the input register is also full
// the input stalls.
module transaction_requester_unit
    import trq_pkg::*;
#(
    parameter int SEGMENT_BYTES = 578
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_xo_mode,
    input  logic [15:0] i_want_len,
    input  logic        i_want_user_bytes,
    input  logic [7:0]  i_attempts,
    input  logic [7:0]  i_retry_interval,
    input  logic [15:0] i_pkt_tid,
    input  logic [2:0]  i_seg_seq,
    input  logic        i_eom,
    input  logic        i_sts,
    input  logic [9:0]  i_data_len,
    input  logic [31:0] i_pkt_user_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_request,
    output logic        o_send_release,
    output logic [15:0] o_tid_out,
    output logic [7:0]  o_req_bitmap,
    output logic [1:0]  o_status,
    output logic        o_write_data,
    output logic [11:0] o_copy_offset,
    output logic [9:0]  o_copy_len,
    output logic [15:0] o_response_len,
    output logic [31:0] o_resp_user_bytes
);

    t_in_item in_item;
    t_in_item held_item;
    t_flow    flow;
    t_result  eng_result;
    t_result  out_result;
    logic     out_free;

    always_comb begin
        in_item.cmd             = t_cmd'(i_cmd);
        in_item.xo_mode         = i_xo_mode;
        in_item.want_len        = i_want_len;
        in_item.want_user_bytes = i_want_user_bytes;
        in_item.attempts        = i_attempts;
        in_item.retry_interval  = i_retry_interval;
        in_item.pkt_tid         = i_pkt_tid;
        in_item.seg_seq         = i_seg_seq;
        in_item.eom             = i_eom;
        in_item.sts             = i_sts;
        in_item.data_len        = i_data_len;
        in_item.pkt_user_bytes  = i_pkt_user_bytes;
    end

    trq_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_item     (held_item),
        .o_flow     (flow)
    );

    trq_engine #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (held_item),
        .i_flow   (flow),
        .o_result (eng_result)
    );

    trq_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (flow.fire),
        .i_result (eng_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_send_request    = out_result.send_request;
    assign o_send_release    = out_result.send_release;
    assign o_tid_out         = out_result.tid_out;
    assign o_req_bitmap      = out_result.req_bitmap;
    assign o_status          = out_result.status;
    assign o_write_data      = out_result.write_data;
    assign o_copy_offset     = out_result.copy_offset;
    assign o_copy_len        = out_result.copy_len;
    assign o_response_len    = out_result.response_len;
    assign o_resp_user_bytes = out_result.resp_user_bytes;

endmodule
